>>> hdl/csel_pkg.sv
// ----------------------------------------------------------------------------
// csel_pkg: shared types and codes for the CSR element lookup
// Field widths, command, status, register and queue operation codes, and the
// queue word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package csel_pkg;

  localparam int ROW_W = 11;
  localparam int OFF_W = 13;
  localparam int POS_W = 12;
  localparam int COL_W = 8;
  localparam int VAL_W = 16;
  localparam int ROW_COUNT_W = 11;
  localparam int COL_COUNT_W = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [1:0] CMD_LOAD_OFFSET = 2'd0;
  localparam logic [1:0] CMD_LOAD_ENTRY = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ROW = 2'd1;
  localparam logic [1:0] STATUS_COLUMN = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Operations the back end carries out.
  localparam logic [1:0] OP_WR_OFFSET = 2'd0;
  localparam logic [1:0] OP_WR_ENTRY = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_REPLY = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [ROW_W-1:0] row;
    logic [OFF_W-1:0] offset;
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
    logic [1:0]       status;
  } queue_item_t;

endpackage

>>> hdl/csr_sparse_element_lookup.sv
// A load or a flagged command is queued, then popped into the result register.
// A lookup reads both offsets of its row, then makes one entry-RAM probe per search step.
// Loads sustain one word per cycle while replies are taken; lookups run one at a time in the back end.
// Reset clears the registers, the queue and the sequencer; the tables stay
// undefined until loaded and get no clearing pass.
// ----------------------------------------------------------------------------
// csr_sparse_element_lookup: compressed-sparse-row element lookup
// Loads row offsets and entries by command and answers point lookups by a
// lower-bound binary search of the row's sorted column indices.
// ----------------------------------------------------------------------------
module csr_sparse_element_lookup #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_COLUMNS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [csel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [csel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       command,
  input  logic [csel_pkg::ROW_W-1:0]       row_index,
  input  logic [csel_pkg::OFF_W-1:0]       offset_value,
  input  logic [csel_pkg::POS_W-1:0]       entry_position,
  input  logic [csel_pkg::COL_W-1:0]       column_index,
  input  logic [csel_pkg::VAL_W-1:0]       entry_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csel_pkg::VAL_W-1:0]       read_value,
  output logic                             found,
  output logic [1:0]                       status
);

  localparam int RAW = $clog2(MAX_ROWS + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW = csel_pkg::COL_W + csel_pkg::VAL_W;

  logic                        q_valid;
  logic                        q_pop;
  csel_pkg::queue_item_t       q_item;
  logic                        off_wr_en;
  logic [RAW-1:0]              off_wr_addr;
  logic [csel_pkg::OFF_W-1:0]  off_wr_data;
  logic                        off_rd_en;
  logic [RAW-1:0]              off_rd_addr;
  logic [csel_pkg::OFF_W-1:0]  off_rd_data;
  logic                        ent_wr_en;
  logic [AW-1:0]               ent_wr_addr;
  logic [EW-1:0]               ent_wr_data;
  logic                        ent_rd_en;
  logic [AW-1:0]               ent_rd_addr;
  logic [EW-1:0]               ent_rd_data;
  logic                        busy;

  csel_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .row_index(row_index),
    .offset_value(offset_value),
    .entry_position(entry_position),
    .column_index(column_index),
    .entry_value(entry_value),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_item(q_item)
  );

  csel_ram #(
    .WIDTH(csel_pkg::OFF_W),
    .DEPTH(MAX_ROWS + 1)
  ) u_offsets (
    .clk(clk),
    .wr_en(off_wr_en),
    .wr_addr(off_wr_addr),
    .wr_data(off_wr_data),
    .rd_en(off_rd_en),
    .rd_addr(off_rd_addr),
    .rd_data(off_rd_data)
  );

  // Column index and value of each entry share one word.
  csel_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ENTRIES)
  ) u_entries (
    .clk(clk),
    .wr_en(ent_wr_en),
    .wr_addr(ent_wr_addr),
    .wr_data(ent_wr_data),
    .rd_en(ent_rd_en),
    .rd_addr(ent_rd_addr),
    .rd_data(ent_rd_data)
  );

  csel_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_item(q_item),
    .off_wr_en(off_wr_en),
    .off_wr_addr(off_wr_addr),
    .off_wr_data(off_wr_data),
    .off_rd_en(off_rd_en),
    .off_rd_addr(off_rd_addr),
    .off_rd_data(off_rd_data),
    .ent_wr_en(ent_wr_en),
    .ent_wr_addr(ent_wr_addr),
    .ent_wr_data(ent_wr_data),
    .ent_rd_en(ent_rd_en),
    .ent_rd_addr(ent_rd_addr),
    .ent_rd_data(ent_rd_data),
    .busy(busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .found(found),
    .status(status)
  );

  // A flagged word never carries a value or a hit.
  a_flag_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != csel_pkg::STATUS_OK |-> read_value == '0 && !found)
    else $error("flagged result carries a value");

  // A hit is only reported for an in-range lookup.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == csel_pkg::STATUS_OK)
    else $error("hit reported with nonzero status");

  // An accepted word is in the queue on the next cycle.
  a_queued: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && in_ready |=> q_valid)
    else $error("accepted word missing from queue");

  // The result register stays empty while a lookup is in progress.
  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> !out_valid)
    else $error("result pending during a lookup");

endmodule

>>> hdl/csel_ram.sv
// ----------------------------------------------------------------------------
// csel_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module csel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/csel_front.sv
// ----------------------------------------------------------------------------
// csel_front: command intake and classification
// Holds the configuration registers, range-checks each accepted word and
// queues a classified operation for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module csel_front #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_COLUMNS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [csel_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [csel_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic [csel_pkg::ROW_W-1:0]          row_index,
  input  logic [csel_pkg::OFF_W-1:0]          offset_value,
  input  logic [csel_pkg::POS_W-1:0]          entry_position,
  input  logic [csel_pkg::COL_W-1:0]          column_index,
  input  logic [csel_pkg::VAL_W-1:0]          entry_value,
  output logic                                q_valid,
  input  logic                                q_pop,
  output csel_pkg::queue_item_t               q_item
);

  logic [csel_pkg::ROW_COUNT_W-1:0] row_count;
  logic [csel_pkg::COL_COUNT_W-1:0] column_count;
  csel_pkg::queue_item_t            slots [2];
  csel_pkg::queue_item_t            item;
  logic [1:0]                       count;
  logic                             wptr;
  logic                             rptr;
  logic                             push;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      column_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        csel_pkg::REG_ROW_COUNT: begin
          row_count <= cfg_data[csel_pkg::ROW_COUNT_W-1:0];
        end
        csel_pkg::REG_COLUMN_COUNT: begin
          column_count <= cfg_data[csel_pkg::COL_COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Loads that fall outside storage, flagged lookups and unused commands become plain replies.
  always_comb begin
    item.row = row_index;
    item.offset = offset_value;
    item.pos = entry_position;
    item.col = column_index;
    item.val = entry_value;
    item.status = csel_pkg::STATUS_OK;
    item.op = csel_pkg::OP_REPLY;
    unique case (command)
      csel_pkg::CMD_LOAD_OFFSET: begin
        if (row_index <= MAX_ROWS) begin
          item.op = csel_pkg::OP_WR_OFFSET;
        end
      end
      csel_pkg::CMD_LOAD_ENTRY: begin
        if (entry_position < MAX_ENTRIES) begin
          item.op = csel_pkg::OP_WR_ENTRY;
        end
      end
      csel_pkg::CMD_LOOKUP: begin
        if (row_index >= row_count || row_index >= MAX_ROWS) begin
          item.status = csel_pkg::STATUS_ROW;
        end else if (column_index >= column_count || column_index >= MAX_COLUMNS) begin
          item.status = csel_pkg::STATUS_COLUMN;
        end else begin
          item.op = csel_pkg::OP_LOOKUP;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hdl/csel_back.sv
// ----------------------------------------------------------------------------
// csel_back: operation sequencer
// Performs table writes and runs the lower-bound search of a lookup over the
// entry RAM, one probe per cycle, then fills the result register.
// ----------------------------------------------------------------------------
module csel_back #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_ENTRIES = 4096,
  localparam int RAW = $clog2(MAX_ROWS + 1),
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int EW = csel_pkg::COL_W + csel_pkg::VAL_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  csel_pkg::queue_item_t         q_item,
  output logic                          off_wr_en,
  output logic [RAW-1:0]                off_wr_addr,
  output logic [csel_pkg::OFF_W-1:0]    off_wr_data,
  output logic                          off_rd_en,
  output logic [RAW-1:0]                off_rd_addr,
  input  logic [csel_pkg::OFF_W-1:0]    off_rd_data,
  output logic                          ent_wr_en,
  output logic [AW-1:0]                 ent_wr_addr,
  output logic [EW-1:0]                 ent_wr_data,
  output logic                          ent_rd_en,
  output logic [AW-1:0]                 ent_rd_addr,
  input  logic [EW-1:0]                 ent_rd_data,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csel_pkg::VAL_W-1:0]    read_value,
  output logic                          found,
  output logic [1:0]                    status
);

  // Position width: holds any offset and MAX_ENTRIES itself.
  localparam int PW = ($clog2(MAX_ENTRIES + 1) > csel_pkg::OFF_W) ?
                      $clog2(MAX_ENTRIES + 1) : csel_pkg::OFF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OFF_A = 3'd1;
  localparam logic [2:0] S_OFF_B = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [RAW-1:0]             row;
  logic [csel_pkg::COL_W-1:0] key;
  logic [PW-1:0]              lo;
  logic [PW-1:0]              hi;
  logic [PW-1:0]              mid;
  logic [PW-1:0]              end_pos;
  logic [PW-1:0]              off_clamped;
  logic [PW-1:0]              lo_cur;
  logic [PW-1:0]              hi_cur;
  logic [PW-1:0]              mid_cur;
  logic                       more;
  logic [csel_pkg::COL_W-1:0] ent_col;
  logic [csel_pkg::VAL_W-1:0] ent_val;
  logic                       reply;
  logic                       fetch_hit;

  function automatic logic [PW-1:0] clamp(input logic [csel_pkg::OFF_W-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    return (w > PW'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : w;
  endfunction

  assign ent_col = ent_rd_data[EW-1:csel_pkg::VAL_W];
  assign ent_val = ent_rd_data[csel_pkg::VAL_W-1:0];
  assign off_clamped = clamp(off_rd_data);
  assign busy = (state != S_IDLE);

  // The result register is empty whenever a lookup runs, so it is free at its end.
  assign q_pop = (state == S_IDLE) && q_valid && (!out_valid || out_ready);
  assign reply = q_pop && (q_item.op != csel_pkg::OP_LOOKUP);

  assign off_wr_en = q_pop && (q_item.op == csel_pkg::OP_WR_OFFSET);
  assign off_wr_addr = RAW'(q_item.row);
  assign off_wr_data = q_item.offset;
  assign ent_wr_en = q_pop && (q_item.op == csel_pkg::OP_WR_ENTRY);
  assign ent_wr_addr = AW'(q_item.pos);
  assign ent_wr_data = {q_item.col, q_item.val};

  assign off_rd_en = (q_pop && (q_item.op == csel_pkg::OP_LOOKUP)) || (state == S_OFF_A);
  assign off_rd_addr = (state == S_OFF_A) ? row + RAW'(1) : RAW'(q_item.row);

  // One search step: narrow the window with the offset or probe just read and pick the next probe.
  always_comb begin
    lo_cur = lo;
    hi_cur = hi;
    case (state)
      S_OFF_B: begin
        hi_cur = off_clamped;
        lo_cur = (lo > off_clamped) ? off_clamped : lo;
      end
      S_SEARCH: begin
        if (ent_col < key) begin
          lo_cur = mid + PW'(1);
        end else begin
          hi_cur = mid;
        end
      end
      default: begin
      end
    endcase
    mid_cur = lo_cur + ((hi_cur - lo_cur) >> 1);
    more = (lo_cur < hi_cur);
  end

  assign ent_rd_en = (state == S_OFF_B) || (state == S_SEARCH);
  assign ent_rd_addr = more ? AW'(mid_cur) : AW'(lo_cur);
  assign fetch_hit = (lo < end_pos) && (ent_col == key);

  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE: begin
        if (q_pop && (q_item.op == csel_pkg::OP_LOOKUP)) begin
          state_next = S_OFF_A;
        end
      end
      S_OFF_A: begin
        state_next = S_OFF_B;
      end
      S_OFF_B, S_SEARCH: begin
        state_next = more ? S_SEARCH : S_FETCH;
      end
      S_FETCH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      row <= RAW'(q_item.row);
      key <= q_item.col;
    end
    if (state == S_OFF_A) begin
      lo <= off_clamped;
    end
    if (state == S_OFF_B || state == S_SEARCH) begin
      lo <= lo_cur;
      hi <= hi_cur;
      mid <= mid_cur;
    end
    if (state == S_OFF_B) begin
      end_pos <= hi_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (reply || state == S_FETCH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reply) begin
      read_value <= '0;
      found <= 1'b0;
      status <= q_item.status;
    end else if (state == S_FETCH) begin
      read_value <= fetch_hit ? ent_val : '0;
      found <= fetch_hit;
      status <= csel_pkg::STATUS_OK;
    end
  end

endmodule

>>> tb/csel_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csel_reply_checker: reply predictor and comparator for the CSR lookup
// Watches the register port and both word channels, keeps its own copy of the
// offset and entry tables, predicts the reply to every accepted command and
// compares each delivered reply with the oldest prediction.
// ----------------------------------------------------------------------------
module csel_reply_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [csel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [csel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       command,
  input  logic [csel_pkg::ROW_W-1:0]       row_index,
  input  logic [csel_pkg::OFF_W-1:0]       offset_value,
  input  logic [csel_pkg::POS_W-1:0]       entry_position,
  input  logic [csel_pkg::COL_W-1:0]       column_index,
  input  logic [csel_pkg::VAL_W-1:0]       entry_value,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [csel_pkg::VAL_W-1:0]       read_value,
  input  logic                             found,
  input  logic [1:0]                       status,
  output int                               fail_count,
  output int                               pending
);

  localparam int ROWS_MAX = 1024;
  localparam int ENTRIES_MAX = 4096;
  localparam int COLUMNS_MAX = 256;

  typedef struct packed {
    logic [csel_pkg::VAL_W-1:0] value;
    logic                       hit;
    logic [1:0]                 status;
  } reply_t;

  logic [csel_pkg::ROW_COUNT_W-1:0] row_limit;
  logic [csel_pkg::COL_COUNT_W-1:0] col_limit;
  logic [csel_pkg::OFF_W-1:0]       offsets [0:ROWS_MAX];
  logic [csel_pkg::COL_W-1:0]       columns [0:ENTRIES_MAX-1];
  logic [csel_pkg::VAL_W-1:0]       values [0:ENTRIES_MAX-1];

  reply_t expected_replies [$];
  reply_t want;
  reply_t seen;
  int     errors = 0;

  function automatic int saturate_offset(input logic [csel_pkg::OFF_W-1:0] offset);
    return (offset > ENTRIES_MAX) ? ENTRIES_MAX : int'(offset);
  endfunction

  // Applies one command to the table copy and returns the reply it earns.
  function automatic reply_t predict_reply(input logic [1:0] cmd,
                                           input logic [csel_pkg::ROW_W-1:0] row,
                                           input logic [csel_pkg::OFF_W-1:0] offset,
                                           input logic [csel_pkg::POS_W-1:0] pos,
                                           input logic [csel_pkg::COL_W-1:0] col,
                                           input logic [csel_pkg::VAL_W-1:0] val);
    reply_t r;
    int     lo;
    int     hi;
    int     row_end;
    int     mid;
    r = '0;
    r.status = csel_pkg::STATUS_OK;
    case (cmd)
      csel_pkg::CMD_LOAD_OFFSET: begin
        if (row <= ROWS_MAX) offsets[row] = offset;
      end
      csel_pkg::CMD_LOAD_ENTRY: begin
        if (pos < ENTRIES_MAX) begin
          columns[pos] = col;
          values[pos] = val;
        end
      end
      csel_pkg::CMD_LOOKUP: begin
        if (row >= row_limit || row >= ROWS_MAX) begin
          r.status = csel_pkg::STATUS_ROW;
        end else if (col >= col_limit || col >= COLUMNS_MAX) begin
          r.status = csel_pkg::STATUS_COLUMN;
        end else begin
          lo = saturate_offset(offsets[row]);
          row_end = saturate_offset(offsets[row + 1]);
          hi = row_end;
          if (lo > hi) lo = hi;
          // Lower-bound search: first position whose column is not below col.
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (columns[mid] < col) lo = mid + 1;
            else hi = mid;
          end
          if (lo < row_end && columns[lo] == col) begin
            r.value = values[lo];
            r.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      row_limit = '0;
      col_limit = '0;
      expected_replies.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          csel_pkg::REG_ROW_COUNT:    row_limit = cfg_data[csel_pkg::ROW_COUNT_W-1:0];
          csel_pkg::REG_COLUMN_COUNT: col_limit = cfg_data[csel_pkg::COL_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_replies.insert(expected_replies.size(),
                                predict_reply(command, row_index, offset_value,
                                              entry_position, column_index,
                                              entry_value));
      end
      if (out_valid && out_ready) begin
        seen = '{value: read_value, hit: found, status: status};
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: reply with none expected: expected nothing, actual %h %b %0d",
                   $time, seen.value, seen.hit, seen.status);
        end else begin
          want = expected_replies.pop_front();
          if (seen.value !== want.value) begin
            errors++;
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.value, seen.value);
          end
          if (seen.hit !== want.hit) begin
            errors++;
            $display("%0t: found mismatch: expected %b, actual %b",
                     $time, want.hit, seen.hit);
          end
          if (seen.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, seen.status);
          end
        end
      end
    end
    fail_count <= errors;
    pending <= expected_replies.size();
  end

endmodule

>>> tb/csr_sparse_element_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_sparse_element_lookup_tb: testbench for the CSR element lookup
// Loads small sparse matrices by command, checks hits, misses, empty and
// reversed rows, saturated offsets and range flags with directed words, then
// runs randomized load and lookup phases under several register settings with
// random stalls on both channels. Replies are checked by csel_reply_checker.
// ----------------------------------------------------------------------------
module csr_sparse_element_lookup_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SLOT_TOP = 1024;
  localparam int ENTRY_LIMIT = 4096;
  localparam int TOTAL_WORDS = 425;
  localparam int HOLD_AT = 45;
  localparam int HOLD_CYCLES = 300;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [csel_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [csel_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       command = csel_pkg::CMD_LOAD_OFFSET;
  logic [csel_pkg::ROW_W-1:0]       row_index = '0;
  logic [csel_pkg::OFF_W-1:0]       offset_value = '0;
  logic [csel_pkg::POS_W-1:0]       entry_position = '0;
  logic [csel_pkg::COL_W-1:0]       column_index = '0;
  logic [csel_pkg::VAL_W-1:0]       entry_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [csel_pkg::VAL_W-1:0]       read_value;
  logic                             found;
  logic [1:0]                       status;

  int fail_count;
  int pending;

  // Stimulus-side record of what the tables hold, so that no lookup ever
  // probes a slot or entry that was never loaded.
  bit                       offset_written [0:SLOT_TOP];
  bit [csel_pkg::OFF_W-1:0] offset_copy [0:SLOT_TOP];
  bit                       entry_written [0:ENTRY_LIMIT-1];
  bit [csel_pkg::COL_W-1:0] column_copy [0:ENTRY_LIMIT-1];
  int                       row_limit = 0;
  int                       col_limit = 0;

  int words_sent = 0;
  int accepted = 0;
  int tx_idle_pct = 30;
  int rx_idle_pct = 56;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  csr_sparse_element_lookup i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .row_index      (row_index),
    .offset_value   (offset_value),
    .entry_position (entry_position),
    .column_index   (column_index),
    .entry_value    (entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_value     (read_value),
    .found          (found),
    .status         (status)
  );

  csel_reply_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .row_index      (row_index),
    .offset_value   (offset_value),
    .entry_position (entry_position),
    .column_index   (column_index),
    .entry_value    (entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_value     (read_value),
    .found          (found),
    .status         (status),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) accepted <= accepted + 1;
  end

  // Reply side: random stalls, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one word and returns at the edge where it is taken, valid still up.
  // Each field takes the low bits of its argument.
  task automatic issue(input logic [1:0] cmd, input int row, input int offset,
                       input int pos, input int col, input int val);
    int                         gap;
    logic [csel_pkg::ROW_W-1:0] row_bits;
    logic [csel_pkg::POS_W-1:0] pos_bits;
    gap = 0;
    row_bits = row[csel_pkg::ROW_W-1:0];
    pos_bits = pos[csel_pkg::POS_W-1:0];
    case (cmd)
      csel_pkg::CMD_LOAD_OFFSET: begin
        if (row_bits <= SLOT_TOP) begin
          offset_written[row_bits] = 1'b1;
          offset_copy[row_bits] = offset[csel_pkg::OFF_W-1:0];
        end
      end
      csel_pkg::CMD_LOAD_ENTRY: begin
        entry_written[pos_bits] = 1'b1;
        column_copy[pos_bits] = col[csel_pkg::COL_W-1:0];
      end
      default: ;
    endcase
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd;
    row_index <= row_bits;
    offset_value <= offset[csel_pkg::OFF_W-1:0];
    entry_position <= pos_bits;
    column_index <= col[csel_pkg::COL_W-1:0];
    entry_value <= val[csel_pkg::VAL_W-1:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (words_sent == 160) begin
      tx_idle_pct = 56;
      rx_idle_pct <= 30;
    end else if (words_sent == 290) begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input int rows, input int columns_data);
    cfg_write <= 1'b1;
    cfg_index <= csel_pkg::REG_ROW_COUNT;
    cfg_data <= rows[csel_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= csel_pkg::REG_COLUMN_COUNT;
    cfg_data <= columns_data[csel_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    row_limit = rows;
    col_limit = int'(columns_data[csel_pkg::COL_COUNT_W-1:0]);
  endtask

  function automatic int clip(input bit [csel_pkg::OFF_W-1:0] offset);
    return (offset > ENTRY_LIMIT) ? ENTRY_LIMIT : int'(offset);
  endfunction

  // True when the lookup is flagged, or when every table word it may probe
  // has been loaded.
  function automatic bit reads_loaded(input int row, input int col);
    if (row >= row_limit || row >= SLOT_TOP || col >= col_limit) return 1'b1;
    if (!offset_written[row] || !offset_written[row + 1]) return 1'b0;
    for (int p = clip(offset_copy[row]); p < clip(offset_copy[row + 1]); p++) begin
      if (!entry_written[p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0: issue(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: issue(csel_pkg::CMD_LOAD_OFFSET, $urandom_range(SLOT_TOP + 1, 2047), $urandom,
                 $urandom, $urandom, $urandom);
        default: issue(csel_pkg::CMD_LOAD_ENTRY, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
      endcase
    end
  endtask

  initial begin
    int nr;
    int base;
    int total;
    int p0;
    int rc;
    int cc;
    int pos;
    int c;
    int r;
    int col;
    int lo;
    int hi;
    int kind;
    int lookups;
    bit tail;
    bit sorted;
    int row_len [12];

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: row 0 sits at the top of storage with a saturated end, row 1
    // is reversed, row 2 holds three entries, row 3 is empty.
    write_regs(4, 256);
    issue(csel_pkg::CMD_LOAD_OFFSET, 0, 4093, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_OFFSET, 1, 8191, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_OFFSET, 2, 0, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_OFFSET, 3, 3, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_OFFSET, 4, 3, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_OFFSET, 1025, 5, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_OFFSET, 2047, 0, 0, 0, 0);
    issue(csel_pkg::CMD_LOAD_ENTRY, 0, 0, 4093, 0, 'hFFFF);
    issue(csel_pkg::CMD_LOAD_ENTRY, 0, 0, 4094, 100, 'h1234);
    issue(csel_pkg::CMD_LOAD_ENTRY, 0, 0, 4095, 255, 'h0001);
    issue(csel_pkg::CMD_LOAD_ENTRY, 0, 0, 0, 5, 'h0000);
    issue(csel_pkg::CMD_LOAD_ENTRY, 0, 0, 1, 7, 'hFFFF);
    issue(csel_pkg::CMD_LOAD_ENTRY, 0, 0, 2, 9, 'h8001);
    issue(CMD_UNUSED, '1, '1, '1, '1, '1);
    issue(csel_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0);
    issue(csel_pkg::CMD_LOOKUP, 0, 0, 0, 255, 0);
    issue(csel_pkg::CMD_LOOKUP, 0, 0, 0, 101, 0);
    issue(csel_pkg::CMD_LOOKUP, 1, 0, 0, 0, 0);
    issue(csel_pkg::CMD_LOOKUP, 2, 0, 0, 7, 0);
    issue(csel_pkg::CMD_LOOKUP, 2, 0, 0, 8, 0);
    issue(csel_pkg::CMD_LOOKUP, 2, 0, 0, 255, 0);
    issue(csel_pkg::CMD_LOOKUP, 3, 0, 0, 5, 0);
    issue(csel_pkg::CMD_LOOKUP, 4, 0, 0, 0, 0);
    issue(csel_pkg::CMD_LOOKUP, 2047, 0, 0, 255, 0);
    drain();
    // Column count 8, with the unused upper data bits set.
    write_regs(4, 'h608);
    issue(csel_pkg::CMD_LOOKUP, 2, 0, 0, 9, 0);
    issue(csel_pkg::CMD_LOOKUP, 4, 0, 0, 255, 0);
    issue(csel_pkg::CMD_LOOKUP, 2, 0, 0, 5, 0);

    // Random phases: load a small matrix somewhere, then look into it.
    while (words_sent < TOTAL_WORDS) begin
      drain();
      nr = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = SLOT_TOP - nr;
        default: base = $urandom_range(0, SLOT_TOP - nr);
      endcase
      total = 0;
      for (int i = 0; i < nr; i++) begin
        row_len[i] = $urandom_range(0, 6);
        total += row_len[i];
      end
      tail = ($urandom_range(0, 3) == 0);
      p0 = tail ? ENTRY_LIMIT - total : $urandom_range(0, ENTRY_LIMIT - total);
      case ($urandom_range(0, 7))
        0: rc = 0;
        1: rc = base + nr;
        2: rc = 1024;
        3: rc = 1025;
        4: rc = 2047;
        default: rc = $urandom_range(base + nr, 2047);
      endcase
      case ($urandom_range(0, 5))
        0: cc = 0;
        1: cc = 511;
        2: cc = $urandom_range(1, 255);
        default: cc = 256;
      endcase
      write_regs(rc, cc | int'($urandom_range(0, 3) << 9));

      pos = p0;
      for (int i = 0; i <= nr; i++) begin
        if (i == nr && tail && $urandom_range(0, 1) == 1)
          issue(csel_pkg::CMD_LOAD_OFFSET, base + i, $urandom_range(4096, 8191), $urandom,
                $urandom, $urandom);
        else
          issue(csel_pkg::CMD_LOAD_OFFSET, base + i, pos, $urandom, $urandom, $urandom);
        if (i < nr) pos += row_len[i];
        maybe_noise();
      end
      // Now and then pull a boundary back so the row before it turns reversed.
      if (nr > 1 && $urandom_range(0, 7) == 0)
        issue(csel_pkg::CMD_LOAD_OFFSET, base + $urandom_range(1, nr - 1),
              $urandom_range(0, p0), $urandom, $urandom, $urandom);

      pos = p0;
      for (int i = 0; i < nr; i++) begin
        sorted = ($urandom_range(0, 9) != 0);
        c = (row_len[i] > 0) ? $urandom_range(0, 255 - 40 * (row_len[i] - 1)) : 0;
        for (int j = 0; j < row_len[i]; j++) begin
          issue(csel_pkg::CMD_LOAD_ENTRY, $urandom, $urandom, pos,
                sorted ? c : $urandom_range(0, 255), $urandom);
          c += $urandom_range(1, 40);
          pos++;
          maybe_noise();
        end
      end

      lookups = $urandom_range(6, 16);
      for (int k = 0; k < lookups; k++) begin
        kind = $urandom_range(0, 9);
        r = base + $urandom_range(0, nr - 1);
        col = $urandom_range(0, 255);
        if (kind < 6 && offset_written[r] && offset_written[r + 1]) begin
          lo = clip(offset_copy[r]);
          hi = clip(offset_copy[r + 1]);
          if (lo < hi) col = int'(column_copy[$urandom_range(lo, hi - 1)]);
        end else if (kind >= 8) begin
          r = $urandom_range(0, 2047);
        end
        // Rows at or above the table size are always flagged.
        if (!reads_loaded(r, col)) r = $urandom_range(SLOT_TOP, 2047);
        issue(csel_pkg::CMD_LOOKUP, r, $urandom, $urandom, col, $urandom);
        maybe_noise();
      end
    end

    drain();
    repeat (25) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
